// ===== hw/rtl/trs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Throttle reset sequencer package
// Item and result records, response, status and command codes.
// ----------------------------------------------------------------------------
package trs_pkg;

	localparam int TIME_W = 32;
	localparam int POS_W  = 16;
	localparam int CODE_W = 8;
	localparam int SUM_W  = 24;
	localparam int CNT_W  = 9;

	localparam logic [1:0] RESP_OK   = 2'd0;
	localparam logic [1:0] RESP_BUSY = 2'd1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PENDING = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_FAULT   = 3'd3;
	localparam logic [2:0] ST_DEVERR  = 3'd4;

	localparam logic [2:0] CMD_NONE      = 3'd0;
	localparam logic [2:0] CMD_MOTOR_DIS = 3'd1;
	localparam logic [2:0] CMD_SELFCHECK = 3'd2;
	localparam logic [2:0] CMD_DIAG_OFF  = 3'd3;
	localparam logic [2:0] CMD_SENS_READ = 3'd4;

	localparam logic [0:0] REG_SENSOR_TIMEOUT = 1'd0;
	localparam logic [0:0] REG_SAMPLE_PERIOD  = 1'd1;

	localparam logic [TIME_W-1:0] SENSOR_TIMEOUT_RST = 32'd100000;
	localparam logic [TIME_W-1:0] SAMPLE_PERIOD_RST  = 32'd1000;

	typedef struct packed {
		logic [TIME_W-1:0] time_us;
		logic              ready_req;
		logic              rst_req;
		logic [1:0]        motor_status;
		logic [CODE_W-1:0] motor_error;
		logic [1:0]        sensor_status;
		logic [CODE_W-1:0] sensor_error;
		logic              sensor_valid;
		logic [POS_W-1:0]  sensor_position;
	} item_t;

	typedef struct packed {
		logic [2:0]        phase;
		logic [2:0]        command;
		logic [2:0]        reset_status;
		logic [CODE_W-1:0] device_error;
		logic [POS_W-1:0]  rest_position;
	} result_t;

	function automatic logic [2:0] cmd_of_phase(input logic [2:0] ph);
		logic [2:0] cmd;
		case (ph)
			3'd1:    cmd = CMD_MOTOR_DIS;
			3'd2:    cmd = CMD_SELFCHECK;
			3'd3:    cmd = CMD_DIAG_OFF;
			3'd4:    cmd = CMD_SENS_READ;
			3'd5:    cmd = CMD_SENS_READ;
			default: cmd = CMD_NONE;
		endcase
		return cmd;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/trs_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Throttle reset sequencer state
// Phase, status and sample state; next state and result for one tick.
// ----------------------------------------------------------------------------
module trs_seq
	import trs_pkg::*;
#(
	parameter int SAMPLE_COUNT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [0:0]        wr_index,
	input  wire logic [TIME_W-1:0] wr_data,
	input  wire logic              fire,
	input  wire item_t             item,
	output result_t                res
);

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_DISABLE     = 3'd1,
		PH_SELFCHECK   = 3'd2,
		PH_DIAGOFF     = 3'd3,
		PH_SENSOR_WAIT = 3'd4,
		PH_SAMPLING    = 3'd5
	} phase_t;

	localparam int DIV      = (SAMPLE_COUNT < 2) ? 2 : SAMPLE_COUNT;
	localparam int DIV_LOG  = $clog2(DIV);
	localparam int SHIFT    = SUM_W + DIV_LOG;
	localparam int RECIP_W  = SUM_W + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam longint RECIP_L = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam logic [CNT_W-1:0]   CNT_DONE = CNT_W'(SAMPLE_COUNT);
	localparam logic [CNT_W-1:0]   CNT_DIV  = CNT_W'(DIV);

	logic [TIME_W-1:0] timeout_q;
	logic [TIME_W-1:0] period_q;

	phase_t            phase_q, phase_d;
	logic [2:0]        status_q, status_d;
	logic [CODE_W-1:0] err_q, err_d;
	logic [TIME_W-1:0] mark_q, mark_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [POS_W-1:0]  defpos_q, defpos_d;

	logic [SUM_W-1:0]  sum_add;
	logic [CNT_W-1:0]  cnt_inc;
	logic [TIME_W-1:0] elapsed;
	logic [PROD_W-1:0] prod;
	logic              m_ok, m_busy, s_ok, s_busy, s_take;

	assign sum_add = sum_q + SUM_W'(item.sensor_position);
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign elapsed = item.time_us - mark_q;
	assign prod    = PROD_W'(sum_add) * PROD_W'(RECIP);
	assign m_ok    = (item.motor_status == RESP_OK);
	assign m_busy  = (item.motor_status == RESP_BUSY);
	assign s_ok    = (item.sensor_status == RESP_OK);
	assign s_busy  = (item.sensor_status == RESP_BUSY);
	assign s_take  = s_ok && item.sensor_valid;

	always_comb begin
		phase_d  = phase_q;
		status_d = status_q;
		err_d    = err_q;
		mark_d   = mark_q;
		sum_d    = sum_q;
		cnt_d    = cnt_q;
		defpos_d = defpos_q;
		if (item.rst_req) begin
			status_d = ST_PENDING;
		end
		case (phase_q)
			PH_IDLE: begin
				if (item.ready_req && status_d == ST_PENDING) begin
					phase_d = PH_DISABLE;
				end
			end
			PH_DISABLE, PH_SELFCHECK, PH_DIAGOFF: begin
				if (m_ok) begin
					case (phase_q)
						PH_DISABLE:   phase_d = PH_SELFCHECK;
						PH_SELFCHECK: phase_d = PH_DIAGOFF;
						default: begin
							phase_d = PH_SENSOR_WAIT;
							mark_d  = item.time_us;
						end
					endcase
				end else if (!m_busy) begin
					status_d = ST_DEVERR;
					err_d    = item.motor_error;
					phase_d  = PH_IDLE;
				end
			end
			PH_SENSOR_WAIT: begin
				if (s_take) begin
					sum_d   = SUM_W'(item.sensor_position);
					cnt_d   = CNT_W'(1);
					mark_d  = item.time_us;
					phase_d = PH_SAMPLING;
				end else if (!s_ok && !s_busy) begin
					status_d = ST_DEVERR;
					err_d    = item.sensor_error;
					phase_d  = PH_IDLE;
				end else if (elapsed > timeout_q) begin
					status_d = ST_TIMEOUT;
					phase_d  = PH_IDLE;
				end
			end
			PH_SAMPLING: begin
				if (elapsed > period_q) begin
					if (s_take) begin
						sum_d = sum_add;
						cnt_d = cnt_inc;
						if (cnt_inc >= CNT_DONE) begin
							defpos_d = prod[SHIFT +: POS_W];
							status_d = ST_OK;
							phase_d  = PH_IDLE;
						end
					end else if (s_ok || s_busy) begin
						status_d = ST_FAULT;
						phase_d  = PH_IDLE;
					end else begin
						status_d = ST_DEVERR;
						err_d    = item.sensor_error;
						phase_d  = PH_IDLE;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		res.phase         = phase_d;
		res.command       = cmd_of_phase(phase_d);
		res.reset_status  = status_d;
		res.device_error  = (status_d == ST_DEVERR) ? err_d : '0;
		res.rest_position = defpos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= SENSOR_TIMEOUT_RST;
			period_q  <= SAMPLE_PERIOD_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SENSOR_TIMEOUT: timeout_q <= wr_data;
				REG_SAMPLE_PERIOD:  period_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			status_q <= ST_OK;
			err_q    <= '0;
			mark_q   <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
			defpos_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			status_q <= status_d;
			err_q    <= err_d;
			mark_q   <= mark_d;
			sum_q    <= sum_d;
			cnt_q    <= cnt_d;
			defpos_q <= defpos_d;
		end
	end

`ifndef SYNTH
	a_sample_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SAMPLING |-> (cnt_q >= CNT_W'(1) && cnt_q < CNT_DIV))
		else $error("sample count out of range while sampling");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_IDLE && status_q != ST_PENDING && !item.rst_req
		|=> phase_q == PH_IDLE)
		else $error("left idle without a pending reset");

	a_motor_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_DISABLE || phase_q == PH_SELFCHECK) |=>
		(phase_q == PH_IDLE || phase_q == $past(phase_q) ||
		 phase_q == phase_t'($past(phase_q) + 3'd1)))
		else $error("motor step jumped phases");

	a_no_change_without_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(status_q) && $stable(cnt_q))
		else $error("sequencer state moved without a transfer");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/trs_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Throttle reset sequencer result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module trs_out
	import trs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res_in,
	input  wire logic    stall,
	output logic         open,
	output logic         valid,
	output result_t      res_q
);

	assign open = !valid || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (open) begin
			valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

`ifndef SYNTH
	a_load_only_when_open: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> open)
		else $error("result loaded over a held result");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/throttle_reset_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Throttle reset sequencer
// Steps motor disable, self-check, diag off, sensor wait and sampling,
// one tick per item, and averages the throttle default position.
// ----------------------------------------------------------------------------
// Path: an item goes through the input register, then the result register.
// Throughput: one item per cycle unless result_stall holds the output;
//   the sequencer state updates once per tick.
// Reset: arst_n clears phase to idle, status to ok, all sums and counts to
//   zero, and loads the timeout and sample period defaults.
module throttle_reset_sequencer_top
	import trs_pkg::*;
#(
	parameter int SAMPLE_COUNT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [0:0]        wr_index,
	input  wire logic [TIME_W-1:0] wr_data,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [TIME_W-1:0] time_us,
	input  wire logic              ready_req,
	input  wire logic              rst_req,
	input  wire logic [1:0]        motor_status,
	input  wire logic [CODE_W-1:0] motor_error,
	input  wire logic [1:0]        sensor_status,
	input  wire logic [CODE_W-1:0] sensor_error,
	input  wire logic              sensor_valid,
	input  wire logic [POS_W-1:0]  sensor_position,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [2:0]             phase,
	output logic [2:0]             command,
	output logic [2:0]             reset_status,
	output logic [CODE_W-1:0]      device_error,
	output logic [POS_W-1:0]       rest_position
);

	logic    valid_s1;
	item_t   item_s1;
	item_t   item_in;
	logic    out_open;
	logic    fire;
	result_t res_next;
	result_t res_q;

	assign item_in = '{
		time_us:         time_us,
		ready_req:       ready_req,
		rst_req:         rst_req,
		motor_status:    motor_status,
		motor_error:     motor_error,
		sensor_status:   sensor_status,
		sensor_error:    sensor_error,
		sensor_valid:    sensor_valid,
		sensor_position: sensor_position
	};

	assign fire       = valid_s1 && out_open;
	assign item_stall = valid_s1 && !out_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_in;
		end
	end

	trs_seq #(
		.SAMPLE_COUNT(SAMPLE_COUNT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.fire     (fire),
		.item     (item_s1),
		.res      (res_next)
	);

	trs_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.res_in (res_next),
		.stall  (result_stall),
		.open   (out_open),
		.valid  (result_valid),
		.res_q  (res_q)
	);

	assign phase         = res_q.phase;
	assign command       = res_q.command;
	assign reset_status  = res_q.reset_status;
	assign device_error  = res_q.device_error;
	assign rest_position = res_q.rest_position;

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && result_valid)
		else $error("input stalled with no item held");
`endif

endmodule
`default_nettype wire
